// ===== design/oidb_pkg.sv =====
// Shared types and constants for the object identifier text to BER encoder.
// Holds the arc job that travels from the front end to the byte emitter.
// No dependencies.
package oidb_pkg;

	localparam int unsigned ArcWidth      = 64;
	localparam int unsigned GroupCount    = 10;
	localparam int unsigned GroupIdxWidth = 4;
	localparam int unsigned QueueDepthDef = 4;
	localparam int unsigned OutDataWidth  = 32;

	localparam logic [7:0] CharDot  = 8'd46;
	localparam logic [7:0] CharZero = 8'd48;
	localparam logic [7:0] TagAbs   = 8'h06;
	localparam logic [7:0] TagRel   = 8'h0d;
	localparam logic [7:0] MoreBit  = 8'h80;

	typedef enum logic {
		OP_CHAR = 1'b0,
		OP_END  = 1'b1
	} op_t;

	typedef struct packed {
		logic [ArcWidth-1:0] value;
		logic                last_arc;
		logic                empty_text;
		logic                abs_form;
	} job_t;

	typedef struct packed {
		logic [7:0] total_length;
		logic [7:0] tag_code;
		logic       content_valid;
		logic [7:0] out_byte;
	} result_t;

	function automatic logic [6:0] arc_group(input logic [ArcWidth-1:0] v,
			input logic [GroupIdxWidth-1:0] g);
		logic [7*GroupCount-1:0] ext;
		ext = {{(7*GroupCount-ArcWidth){1'b0}}, v};
		if (g >= GroupIdxWidth'(GroupCount)) begin
			return 7'd0;
		end
		return ext[7*g +: 7];
	endfunction

	function automatic logic [GroupIdxWidth-1:0] top_group(input logic [ArcWidth-1:0] v);
		logic [GroupIdxWidth-1:0] top;
		top = '0;
		for (int g = 1; g < GroupCount; g++) begin
			if (arc_group(v, GroupIdxWidth'(g)) != 7'd0) begin
				top = GroupIdxWidth'(g);
			end
		end
		return top;
	endfunction

endpackage

// ===== design/oidb_front.sv =====
// Front end of the encoder: accepts characters, accumulates arcs in decimal
// and hands finished arcs to the job queue. Depends on oidb_pkg.
module oidb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_op,
	input  logic [7:0]    in_char,
	output logic          push_valid,
	input  logic          push_full,
	output oidb_pkg::job_t push_job
);
	import oidb_pkg::*;

	logic                started_q;
	logic                abs_q;
	logic [ArcWidth-1:0] arc_q;
	logic [ArcWidth-1:0] first_q;
	logic [1:0]          cnt_q;

	logic                accept;
	logic                is_dot;
	logic                abs_eff;
	logic [ArcWidth-1:0] merged;
	logic [ArcWidth-1:0] arc_next;
	logic                do_merge;

	assign in_ready = !push_full;
	assign accept   = in_valid && in_ready;
	assign is_dot   = (in_char == CharDot);
	assign abs_eff  = started_q ? abs_q : !is_dot;
	assign merged   = arc_q + (first_q << 5) + (first_q << 3);
	assign arc_next = (arc_q << 3) + (arc_q << 1) + ArcWidth'(in_char) - ArcWidth'(CharZero);
	assign do_merge = abs_eff && (cnt_q == 2'd1);

	always_comb begin
		push_valid          = 1'b0;
		push_job.value      = do_merge ? merged : arc_q;
		push_job.last_arc   = 1'b0;
		push_job.empty_text = 1'b0;
		push_job.abs_form   = abs_eff;
		if (accept) begin
			if (in_op == OP_END) begin
				push_valid          = 1'b1;
				push_job.last_arc   = 1'b1;
				push_job.empty_text = !started_q;
			end else if (is_dot && started_q) begin
				push_valid = (cnt_q != 2'd0) || !abs_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			abs_q     <= 1'b0;
			arc_q     <= '0;
			first_q   <= '0;
			cnt_q     <= 2'd0;
		end else if (accept) begin
			if (in_op == OP_END) begin
				started_q <= 1'b0;
				abs_q     <= 1'b0;
				arc_q     <= '0;
				first_q   <= '0;
				cnt_q     <= 2'd0;
			end else if (!started_q && is_dot) begin
				started_q <= 1'b1;
				abs_q     <= 1'b0;
			end else begin
				started_q <= 1'b1;
				abs_q     <= abs_eff;
				if (is_dot) begin
					if (abs_eff && cnt_q == 2'd0) begin
						first_q <= arc_q;
					end
					arc_q <= '0;
					if (cnt_q != 2'd2) begin
						cnt_q <= cnt_q + 2'd1;
					end
				end else begin
					arc_q <= arc_next;
				end
			end
		end
	end

endmodule

// ===== design/oidb_fifo.sv =====
// Short queue of arc jobs between the front end and the byte emitter.
// Depends on oidb_pkg.
module oidb_fifo #(
	parameter int unsigned DEPTH = oidb_pkg::QueueDepthDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  oidb_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output oidb_pkg::job_t head_job,
	output logic           empty
);
	import oidb_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/oidb_back.sv =====
// Back end of the encoder: splits each queued arc into base-128 bytes, keeps
// the content length and drives the registered result channel. Depends on oidb_pkg.
module oidb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_empty,
	input  oidb_pkg::job_t job,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output oidb_pkg::result_t out_res,
	output logic           out_last
);
	import oidb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t                   state_q;
	job_t                     cur_q;
	logic [GroupIdxWidth-1:0] grp_q;
	logic [7:0]               len_q;
	logic                     oval_q;
	result_t                  ores_q;
	logic                     olast_q;

	logic       advance;
	logic       end_of_arc;
	logic [7:0] len_next;
	logic [6:0] grp_bits;
	result_t    res;
	logic       res_last;

	assign out_valid  = oval_q;
	assign out_res    = ores_q;
	assign out_last   = olast_q;
	assign job_pop    = (state_q == ST_IDLE) && !job_empty;
	assign advance    = (state_q == ST_EMIT) && (!oval_q || out_ready);
	assign end_of_arc = cur_q.empty_text || (grp_q == '0);
	assign len_next   = len_q + 8'd1;
	assign grp_bits   = arc_group(cur_q.value, grp_q);

	always_comb begin
		res_last = cur_q.last_arc && end_of_arc;
		if (cur_q.empty_text) begin
			res.out_byte      = 8'd0;
			res.content_valid = 1'b0;
			res.tag_code      = 8'd0;
			res.total_length  = 8'd0;
		end else begin
			res.out_byte      = (grp_q == '0) ? {1'b0, grp_bits} : (MoreBit | {1'b0, grp_bits});
			res.content_valid = 1'b1;
			res.tag_code      = cur_q.abs_form ? TagAbs : TagRel;
			res.total_length  = res_last ? len_next : 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
			grp_q <= top_group(job.value);
		end else if (advance && !end_of_arc) begin
			grp_q <= grp_q - GroupIdxWidth'(1);
		end
		if (advance) begin
			ores_q  <= res;
			olast_q <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= 8'd0;
			oval_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (advance && end_of_arc) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (advance) begin
				len_q <= (res_last || cur_q.empty_text) ? 8'd0 : len_next;
			end
			if (advance) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/oid_text_to_ber_encoder_unit.sv =====
// Object identifier text to BER content bytes encoder, top level.
// Instantiates oidb_front, oidb_fifo and oidb_back; depends on oidb_pkg.
//
// The slave channel carries one character per transfer in s_tdata, with
// s_tuser high on the transfer that marks the end of the text. The master
// channel carries one content byte per transfer; m_tlast marks the final
// byte of an identifier, which also holds the content length.
// Characters are taken one per cycle while the queue has room. A dot or
// the end of text hands the finished arc to a queue of QUEUE_DEPTH entries;
// the emitter drains it, loading each arc and then sending one byte per
// cycle while the receiver keeps up. With the queue empty, the first byte
// of an arc passes through the queue, the job register and the result
// register. Digits keep flowing while bytes drain; s_tready drops only
// while the queue is full. When m_tready is low the result register holds
// its transfer and the emitter waits, and the queue absorbs further arcs
// until it fills. Reset clears the accumulator, the queue and the result
// valid flag; the block is ready for the first character once reset ends.
module oid_text_to_ber_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = oidb_pkg::QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tuser,  // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [oidb_pkg::OutDataWidth-1:0] m_tdata,
	// [7:0] out_byte, [8] content_valid, [16:9] tag_code, [24:17] total_length
	output logic        m_tlast
);
	import oidb_pkg::*;

	logic    push_valid;
	logic    push_full;
	job_t    push_job;
	logic    pop;
	logic    q_empty;
	job_t    head_job;
	result_t res;

	oidb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_char    (s_tdata),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_job   (push_job)
	);

	oidb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_job (push_job),
		.full     (push_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	oidb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job       (head_job),
		.job_pop   (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(OutDataWidth - $bits(result_t)){1'b0}}, res};

endmodule

// ===== design/oidb_checker.sv =====
// Port-level checks for the encoder top level, attached by bind.
// Depends on oidb_pkg and the ports of oid_text_to_ber_encoder_unit.
module oidb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [oidb_pkg::OutDataWidth-1:0] m_tdata,
	input logic        m_tlast
);
	import oidb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled result transfer changed.");

	a_empty_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tlast && m_tdata[24:0] == 25'd0)
		else $error("Empty-text result is malformed.");

	a_inner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[8] && m_tdata[24:17] == 8'd0
			&& (m_tdata[16:9] == TagAbs || m_tdata[16:9] == TagRel))
		else $error("Non-final result is malformed.");

	a_final_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tdata[8] |-> !m_tdata[7])
		else $error("Final byte has its continuation bit set.");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:25] == 7'd0)
		else $error("Padding bits are not zero.");

endmodule

bind oid_text_to_ber_encoder_unit oidb_checker u_oidb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== dv/tb_oid_text_to_ber_encoder_unit.sv =====
`timescale 1ns / 1ps
// Testbench for oid_text_to_ber_encoder_unit: streams dotted identifier text in and checks
// every encoded content byte against a cycle-free predictor. Depends on oidb_pkg and the RTL.
module tb_oid_text_to_ber_encoder_unit;
	import oidb_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       content_valid;
		logic [7:0] tag_code;
		logic [7:0] total_length;
		logic       is_last;
	} enc_byte_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic       typed;
		enc_byte_t  res;
	} dir_row_t;

	localparam int DirRows = 24;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [OutDataWidth-1:0] m_tdata;
	logic        m_tlast;

	enc_byte_t   pending_bytes[$];
	dir_row_t    dir_rows[DirRows];
	int          err_count = 0;
	int          items_sent = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_req = 0;
	int          hold_left = 0;

	logic        txt_started;
	logic        txt_absolute;
	logic [63:0] cur_arc;
	logic [63:0] first_arc_val;
	logic [1:0]  arcs_seen;
	logic [7:0]  byte_count;

	oid_text_to_ber_encoder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void enc_reset();
		txt_started   = 1'b0;
		txt_absolute  = 1'b0;
		cur_arc       = '0;
		first_arc_val = '0;
		arcs_seen     = '0;
		byte_count    = '0;
	endfunction

	// Splits one arc into base-128 groups, most significant first, leading zero groups dropped.
	function automatic void enc_arc_bytes(input logic [63:0] v, input logic fin);
		logic [7:0] tag;
		logic [6:0] grp;
		logic       lead;
		enc_byte_t  b;
		tag  = txt_absolute ? TagAbs : TagRel;
		lead = 1'b0;
		for (int g = 9; g >= 0; g--) begin
			grp = 7'((v >> (7 * g)) & 64'h7f);
			if (g == 0) begin
				byte_count = byte_count + 8'd1;
				b = '{{1'b0, grp}, 1'b1, tag, fin ? byte_count : 8'd0, fin};
				pending_bytes.push_back(b);
			end else if (lead || grp != 7'd0) begin
				lead = 1'b1;
				byte_count = byte_count + 8'd1;
				b = '{{1'b0, grp} | MoreBit, 1'b1, tag, 8'd0, 1'b0};
				pending_bytes.push_back(b);
			end
		end
	endfunction

	function automatic void enc_step(input op_t op, input logic [7:0] ch);
		enc_byte_t b;
		if (op == OP_END) begin
			if (!txt_started) begin
				b = '{8'd0, 1'b0, 8'd0, 8'd0, 1'b1};
				pending_bytes.push_back(b);
			end else begin
				if (txt_absolute && arcs_seen == 2'd1) begin
					cur_arc = cur_arc + 64'd40 * first_arc_val;
				end
				enc_arc_bytes(cur_arc, 1'b1);
			end
			enc_reset();
			return;
		end
		if (!txt_started) begin
			txt_started = 1'b1;
			if (ch == CharDot) begin
				txt_absolute = 1'b0;
				return;
			end
			txt_absolute = 1'b1;
		end
		if (ch == CharDot) begin
			if (txt_absolute) begin
				if (arcs_seen == 2'd0) begin
					first_arc_val = cur_arc;
				end else if (arcs_seen == 2'd1) begin
					cur_arc = cur_arc + 64'd40 * first_arc_val;
				end
			end
			if (arcs_seen > 2'd0 || !txt_absolute) begin
				enc_arc_bytes(cur_arc, 1'b0);
			end
			cur_arc = '0;
			if (arcs_seen < 2'd2) begin
				arcs_seen = arcs_seen + 2'd1;
			end
		end else begin
			cur_arc = cur_arc * 64'd10 + {56'd0, ch} - {56'd0, CharZero};
		end
	endfunction

	task automatic put_item(input op_t op, input logic [7:0] ch, input logic typed = 1'b0,
			input enc_byte_t typed_res = '0);
		int mark;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		mark = pending_bytes.size();
		enc_step(op, ch);
		if (typed) begin
			while (pending_bytes.size() > mark) begin
				void'(pending_bytes.pop_back());
			end
			pending_bytes.push_back(typed_res);
		end
		items_sent++;
	endtask

	task automatic wait_all_out();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic random_texts(input int target);
		int start;
		int kind;
		int n_arcs;
		int n_dig;
		logic [7:0] ch;
		start = items_sent;
		while (items_sent - start < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 5) begin
				put_item(OP_END, 8'($urandom_range(0, 255)));
			end else if (kind < 15) begin
				repeat ($urandom_range(1, 6)) begin
					put_item(OP_CHAR, 8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 9) != 0) begin
					put_item(OP_END, 8'($urandom_range(0, 255)));
				end
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					put_item(OP_CHAR, CharDot);
				end
				n_arcs = $urandom_range(1, 5);
				for (int a = 0; a < n_arcs; a++) begin
					if (a > 0) begin
						put_item(OP_CHAR, CharDot);
					end
					n_dig = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 22)
							: $urandom_range(1, 4);
					repeat (n_dig) begin
						if ($urandom_range(0, 29) == 0) begin
							ch = 8'($urandom_range(0, 255));
						end else begin
							ch = CharZero + 8'($urandom_range(0, 9));
						end
						put_item(OP_CHAR, ch);
					end
				end
				if ($urandom_range(0, 9) == 0) begin
					put_item(OP_CHAR, CharDot);
				end
				put_item(OP_END, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		enc_byte_t want;
		enc_byte_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tdata[8], m_tdata[16:9], m_tdata[24:17], m_tlast};
			if (pending_bytes.size() == 0) begin
				$error("Unexpected transfer: out_byte %0h, is_last %0b.", got.out_byte,
						got.is_last);
				err_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (got.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
					err_count++;
				end
				if (got.content_valid !== want.content_valid) begin
					$error("content_valid: expected %0b, actual %0b", want.content_valid,
							got.content_valid);
					err_count++;
				end
				if (got.tag_code !== want.tag_code) begin
					$error("tag_code: expected %0h, actual %0h", want.tag_code, got.tag_code);
					err_count++;
				end
				if (got.total_length !== want.total_length) begin
					$error("total_length: expected %0d, actual %0d", want.total_length,
							got.total_length);
					err_count++;
				end
				if (got.is_last !== want.is_last) begin
					$error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
					err_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		enc_reset();
		dir_rows = '{
			'{OP_END,  8'h00,    1'b1, '{8'h00, 1'b0, 8'h00,  8'd0, 1'b1}},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_END,  8'hff,    1'b1, '{8'h00, 1'b1, TagRel, 8'd1, 1'b1}},
			'{OP_CHAR, "1",      1'b0, '0},
			'{OP_END,  8'h00,    1'b1, '{8'h01, 1'b1, TagAbs, 8'd1, 1'b1}},
			'{OP_CHAR, "2",      1'b0, '0},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_CHAR, "3",      1'b0, '0},
			'{OP_CHAR, "9",      1'b0, '0},
			'{OP_END,  8'h00,    1'b1, '{8'h77, 1'b1, TagAbs, 8'd1, 1'b1}},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_CHAR, 8'h00,    1'b0, '0},
			'{OP_END,  8'h00,    1'b0, '0},
			'{OP_CHAR, 8'hff,    1'b0, '0},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_CHAR, 8'h00,    1'b0, '0},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_CHAR, "5",      1'b0, '0},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_END,  8'h00,    1'b0, '0},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_CHAR, CharDot,  1'b0, '0},
			'{OP_CHAR, "7",      1'b0, '0},
			'{OP_END,  8'h00,    1'b0, '0}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DirRows; i++) begin
			put_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].res);
		end
		wait_all_out();

		// Each arc of a relative identifier below wraps to a ten-byte value, so the
		// content length passes 255.
		put_item(OP_CHAR, CharDot);
		repeat (26) begin
			put_item(OP_CHAR, 8'h00);
			put_item(OP_CHAR, CharDot);
		end
		put_item(OP_END, 8'h00);
		wait_all_out();

		// The receiver holds off while short arcs keep closing, so the arc queue fills.
		hold_req = 400;
		put_item(OP_CHAR, CharDot);
		repeat (30) begin
			put_item(OP_CHAR, "9");
			put_item(OP_CHAR, CharDot);
		end
		put_item(OP_END, 8'h00);
		wait_all_out();

		random_texts(65);
		wait_all_out();

		idle_pct = 81;
		stall_pct = 0;
		random_texts(65);
		wait_all_out();

		idle_pct = 0;
		stall_pct = 81;
		random_texts(65);
		wait_all_out();

		idle_pct = 29;
		stall_pct = 29;
		random_texts(65);
		wait_all_out();

		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
